FILE: src/urd_pkg.sv
// Package for the update response deframer.
// Holds the frame constants, byte codes, phase codes and the result type.
// It has no dependencies.
package urd_pkg;

  localparam int unsigned FrameBytesDefault = 10;

  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] StartByte = 8'h7E;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] HdrByte1  = 8'h5E;
  localparam logic [7:0] HdrByte2  = 8'h50;

  localparam logic [7:0] PrimPowerupAck = 8'h80;
  localparam logic [7:0] PrimVersionAck = 8'h81;
  localparam logic [7:0] PrimDataReq    = 8'h82;
  localparam logic [7:0] PrimEnd        = 8'h83;
  localparam logic [7:0] PrimCrcError   = 8'h84;

  localparam logic [15:0] TimeoutReset = 16'd100;

  localparam logic [3:0] PhIdle       = 4'd0;
  localparam logic [3:0] PhPowerupReq = 4'd1;
  localparam logic [3:0] PhPowerupAck = 4'd2;
  localparam logic [3:0] PhVersionReq = 4'd3;
  localparam logic [3:0] PhVersionAck = 4'd4;
  localparam logic [3:0] PhTransfer   = 4'd5;
  localparam logic [3:0] PhDataReq    = 4'd6;
  localparam logic [3:0] PhComplete   = 4'd7;
  localparam logic [3:0] PhFail       = 4'd8;

  typedef enum logic [1:0] {
    FuncByte  = 2'd0,
    FuncPhase = 2'd1,
    FuncTick  = 2'd2
  } func_e;

  typedef struct packed {
    logic [3:0]  phase;
    logic        frame_done;
    logic        timed_out;
    logic [7:0]  primitive_res;
    logic [31:0] request_address;
  } res_t;

endpackage

FILE: src/urd_in_if.sv
// Input channel of the update response deframer: valid, ready and one item.
// It has no dependencies.
interface urd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;
  logic [3:0] new_phase;

  modport source (output valid, output func, output rx_byte, output new_phase, input ready);
  modport sink (input valid, input func, input rx_byte, input new_phase, output ready);
endinterface

FILE: src/urd_out_if.sv
// Result channel of the update response deframer: valid, ready and one item.
// It has no dependencies.
interface urd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  phase;
  logic        frame_done;
  logic        timed_out;
  logic [7:0]  primitive_res;
  logic [31:0] request_address;

  modport source (output valid, output phase, output frame_done, output timed_out,
                  output primitive_res, output request_address, input ready);
  modport sink (input valid, input phase, input frame_done, input timed_out,
                input primitive_res, input request_address, output ready);
endinterface

FILE: src/update_response_deframer.sv
// Update response deframer top level; uses urd_pkg, urd_in_if and urd_out_if.
// The result of an accepted item is registered in the output register, or in the skid register while
// the output register holds a result not yet taken. Throughput: one item per cycle while the skid
// entry is empty; this two-entry output buffer keeps input ready high while one finished result waits.
// Reset (rst_ni, asynchronous, active low) clears phase, count, escape,
// idle count, address and buffer, and sets the timeout to 100 ticks.
module update_response_deframer #(
  parameter int unsigned FRAME_BYTES = urd_pkg::FrameBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  urd_in_if.sink      rx_i,
  urd_out_if.source   res_o
);

  localparam int unsigned CntW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [CntW-1:0] LastCnt = CntW'(FRAME_BYTES - 1);

  logic [15:0]     timeout_q;
  logic [3:0]      phase_q, phase_d;
  logic [CntW-1:0] count_q, count_d;
  logic            esc_q, esc_d;
  logic [31:0]     addr_q, addr_d;
  logic [15:0]     idle_q, idle_d;
  logic [7:0]      store_q [FRAME_BYTES];

  logic [7:0]      val;
  logic            store_we;
  logic [7:0]      view [8];
  logic            push, pop;
  urd_pkg::res_t   res_new;
  urd_pkg::res_t   out_q, skid_q;
  logic            out_valid_q, skid_valid_q;

  assign push = rx_i.valid & rx_i.ready;
  assign pop  = out_valid_q & res_o.ready;
  assign rx_i.ready = ~skid_valid_q;

  assign val = esc_q ? (rx_i.rx_byte ^ urd_pkg::EscXor) : rx_i.rx_byte;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (count_q == CntW'(k)) begin
        view[k] = val;
      end else begin
        view[k] = store_q[k];
      end
    end
  end

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    esc_d    = esc_q;
    addr_d   = addr_q;
    idle_d   = idle_q;
    store_we = 1'b0;
    res_new  = '0;
    case (urd_pkg::func_e'(rx_i.func))
      urd_pkg::FuncByte: begin
        idle_d = '0;
        if (rx_i.rx_byte == urd_pkg::EscByte) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          if (count_q != '0 || rx_i.rx_byte == urd_pkg::StartByte) begin
            store_we = 1'b1;
            count_d  = count_q + 1'b1;
            if (count_q == LastCnt) begin
              count_d = '0;
              res_new.frame_done    = 1'b1;
              res_new.primitive_res = view[3];
              if (view[1] == urd_pkg::HdrByte1 && view[2] == urd_pkg::HdrByte2) begin
                case (view[3])
                  urd_pkg::PrimPowerupAck: begin
                    if (phase_q == urd_pkg::PhPowerupReq) phase_d = urd_pkg::PhPowerupAck;
                  end
                  urd_pkg::PrimVersionAck: begin
                    if (phase_q == urd_pkg::PhVersionReq) phase_d = urd_pkg::PhVersionAck;
                  end
                  urd_pkg::PrimDataReq: begin
                    if (phase_q == urd_pkg::PhTransfer) begin
                      phase_d = urd_pkg::PhDataReq;
                      addr_d  = {view[7], view[6], view[5], view[4]};
                    end
                  end
                  urd_pkg::PrimEnd:      phase_d = urd_pkg::PhComplete;
                  urd_pkg::PrimCrcError: phase_d = urd_pkg::PhFail;
                  default: ;
                endcase
              end
            end
          end
        end
      end
      urd_pkg::FuncPhase: begin
        if (rx_i.new_phase <= urd_pkg::PhFail) phase_d = rx_i.new_phase;
      end
      urd_pkg::FuncTick: begin
        if (idle_q >= timeout_q) begin
          count_d = '0;
          esc_d   = 1'b0;
          idle_d  = '0;
          res_new.timed_out = 1'b1;
        end else begin
          idle_d = idle_q + 16'd1;
        end
      end
      default: ;
    endcase
    res_new.phase           = phase_d;
    res_new.request_address = addr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= urd_pkg::TimeoutReset;
      phase_q      <= urd_pkg::PhIdle;
      count_q      <= '0;
      esc_q        <= 1'b0;
      addr_q       <= '0;
      idle_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (push) begin
        phase_q <= phase_d;
        count_q <= count_d;
        esc_q   <= esc_d;
        addr_q  <= addr_d;
        idle_q  <= idle_d;
      end
      if (skid_valid_q) begin
        if (pop) skid_valid_q <= 1'b0;
      end else if (push) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && store_we) store_q[count_q[IdxW-1:0]] <= val;
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (!out_valid_q || pop) begin
        out_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.phase           = out_q.phase;
  assign res_o.frame_done      = out_q.frame_done;
  assign res_o.timed_out       = out_q.timed_out;
  assign res_o.primitive_res   = out_q.primitive_res;
  assign res_o.request_address = out_q.request_address;

endmodule

FILE: verif/update_response_deframer_tb.sv
// Self-checking testbench for the update response deframer: random and directed
// response byte streams, host phase writes and ticks, checked item by item.
// Depends on urd_pkg, urd_in_if, urd_out_if and update_response_deframer.
module update_response_deframer_tb;
  import urd_pkg::*;

  localparam int FrameLen = 10;
  localparam int StuckLimit = 1000;
  localparam int LongHold = 80;
  localparam int SessionItems = 160;
  localparam logic [1:0] FuncUnused = 2'd3;

  typedef struct packed {
    logic [1:0] fn;
    logic [7:0] rb;
    logic [3:0] np;
  } line_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  urd_in_if rx_if ();
  urd_out_if res_if ();

  update_response_deframer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_i        (rx_if),
    .res_o       (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted block state.
  logic [3:0]  pr_phase = PhIdle;
  int          pr_count = 0;
  logic        pr_esc = 1'b0;
  logic [7:0]  pr_frame [FrameLen];
  logic [31:0] pr_addr = '0;
  logic [15:0] pr_idle = '0;
  logic [15:0] tmo_limit = TimeoutReset;

  line_item_t line_items [$];
  res_t due_reports [$];
  line_item_t cur_item;
  logic in_taken = 1'b0;
  int send_gap = 0;
  int recv_hold = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int long_req = 0;
  int long_served = 0;
  int n_queued = 0;
  int n_items = 0;
  int n_frames = 0;
  int n_timeouts = 0;
  int n_errors = 0;
  int stuck_cycles = 0;

  function automatic res_t deframe_step(logic [1:0] fn, logic [7:0] rb, logic [3:0] np);
    res_t r;
    logic [7:0] val;
    r = '0;
    case (fn)
      FuncByte: begin
        pr_idle = '0;
        if (rb == EscByte) begin
          pr_esc = 1'b1;
        end else begin
          val = pr_esc ? (rb ^ EscXor) : rb;
          pr_esc = 1'b0;
          if (pr_count > 0 || rb == StartByte) begin
            pr_frame[pr_count] = val;
            pr_count++;
            if (pr_count >= FrameLen) begin
              if (pr_frame[1] == HdrByte1 && pr_frame[2] == HdrByte2) begin
                case (pr_frame[3])
                  PrimPowerupAck: if (pr_phase == PhPowerupReq) pr_phase = PhPowerupAck;
                  PrimVersionAck: if (pr_phase == PhVersionReq) pr_phase = PhVersionAck;
                  PrimDataReq: begin
                    if (pr_phase == PhTransfer) begin
                      pr_addr = {pr_frame[7], pr_frame[6], pr_frame[5], pr_frame[4]};
                      pr_phase = PhDataReq;
                    end
                  end
                  PrimEnd: pr_phase = PhComplete;
                  PrimCrcError: pr_phase = PhFail;
                  default: ;
                endcase
              end
              r.primitive_res = pr_frame[3];
              r.frame_done = 1'b1;
              pr_count = 0;
              pr_esc = 1'b0;
            end
          end
        end
      end
      FuncPhase: begin
        if (np <= PhFail) pr_phase = np;
      end
      FuncTick: begin
        if (pr_idle >= tmo_limit) begin
          pr_count = 0;
          pr_esc = 1'b0;
          pr_idle = '0;
          r.timed_out = 1'b1;
        end else begin
          pr_idle++;
        end
      end
      default: ;
    endcase
    r.phase = pr_phase;
    r.request_address = pr_addr;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Sender.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!rx_if.valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          rx_if.valid <= 1'b0;
        end else if (line_items.size() > 0) begin
          cur_item = line_items.pop_front();
          rx_if.valid <= 1'b1;
          rx_if.func <= cur_item.fn;
          rx_if.rx_byte <= cur_item.rb;
          rx_if.new_phase <= cur_item.np;
          send_gap = pick_gap(send_idle_pct);
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_hold > 0) begin
        recv_hold--;
        res_if.ready <= 1'b0;
      end else if (long_served != long_req) begin
        long_served++;
        recv_hold = LongHold - 1;
        res_if.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_hold = pick_gap(100) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor, predictor and watchdog.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      in_taken <= rx_if.valid && rx_if.ready;
      if (res_if.valid && res_if.ready) begin
        got.phase = res_if.phase;
        got.frame_done = res_if.frame_done;
        got.timed_out = res_if.timed_out;
        got.primitive_res = res_if.primitive_res;
        got.request_address = res_if.request_address;
        if (due_reports.size() == 0) begin
          $display("%0t: unexpected item, actual 0x%0h", $time, got);
          n_errors++;
        end else begin
          want = due_reports.pop_front();
          check_field("phase", 32'(want.phase), 32'(got.phase));
          check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
          check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
          check_field("primitive_res", 32'(want.primitive_res), 32'(got.primitive_res));
          check_field("request_address", want.request_address, got.request_address);
          n_frames += int'(want.frame_done);
          n_timeouts += int'(want.timed_out);
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        due_reports.push_back(deframe_step(rx_if.func, rx_if.rx_byte, rx_if.new_phase));
        n_items++;
      end
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= StuckLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, StuckLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic push_item(logic [1:0] fn, logic [7:0] rb, logic [3:0] np);
    line_items.push_back('{fn: fn, rb: rb, np: np});
    n_queued++;
  endtask

  task automatic push_byte(logic [7:0] b);
    push_item(FuncByte, b, 4'($urandom_range(0, 15)));
  endtask

  task automatic push_phase(logic [3:0] p);
    push_item(FuncPhase, 8'($urandom), p);
  endtask

  task automatic push_tick();
    push_item(FuncTick, 8'($urandom), 4'($urandom_range(0, 15)));
  endtask

  // Sends the first nbytes of a stuffed frame, with ticks between bytes now and then.
  task automatic push_frame(logic [7:0] prim, logic [31:0] addr, bit hdr_ok, int nbytes,
                            int tick_pct);
    logic [7:0] body [FrameLen];
    body[0] = StartByte;
    body[1] = hdr_ok ? HdrByte1 : 8'($urandom);
    body[2] = hdr_ok ? HdrByte2 : 8'($urandom);
    body[3] = prim;
    body[4] = addr[7:0];
    body[5] = addr[15:8];
    body[6] = addr[23:16];
    body[7] = addr[31:24];
    body[8] = 8'($urandom);
    body[9] = 8'($urandom);
    push_byte(StartByte);
    for (int i = 1; i < nbytes; i++) begin
      if ($urandom_range(0, 99) < tick_pct) push_tick();
      if (body[i] == EscByte || body[i] == StartByte ||
          (body[i] != (EscByte ^ EscXor) && $urandom_range(0, 7) == 0)) begin
        push_byte(EscByte);
        push_byte(body[i] ^ EscXor);
      end else begin
        push_byte(body[i]);
      end
    end
  endtask

  task automatic gen_session(int n);
    int first;
    int r;
    int len;
    int lim;
    logic [7:0] prim;
    logic [31:0] addr;
    first = n_queued;
    while (n_queued - first < n) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: addr = '0;
        1: addr = '1;
        default: addr = $urandom;
      endcase
      case ($urandom_range(0, 6))
        0: prim = PrimPowerupAck;
        1: prim = PrimVersionAck;
        2: prim = PrimDataReq;
        3: prim = PrimEnd;
        4: prim = PrimCrcError;
        default: prim = 8'($urandom);
      endcase
      if (r < 55) begin
        if ($urandom_range(0, 9) < 7) begin
          case (prim)
            PrimPowerupAck: push_phase(PhPowerupReq);
            PrimVersionAck: push_phase(PhVersionReq);
            PrimDataReq: push_phase(PhTransfer);
            default: push_phase(4'($urandom_range(0, 8)));
          endcase
        end
        push_frame(prim, addr, $urandom_range(0, 9) != 0, FrameLen, 5);
      end else if (r < 65) begin
        lim = (tmo_limit > 118) ? 120 : int'(tmo_limit) + 2;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, lim) : $urandom_range(1, 4);
        repeat (len) push_tick();
      end else if (r < 75) begin
        push_phase(4'($urandom_range(0, 15)));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
      end else if (r < 93) begin
        push_frame(prim, addr, 1'b1, $urandom_range(1, FrameLen - 1), 30);
      end else if (r < 97) begin
        push_item(FuncUnused, 8'($urandom), 4'($urandom_range(0, 15)));
      end else begin
        push_byte(EscByte);
        push_byte(StartByte ^ EscXor);
      end
    end
  endtask

  task automatic wait_quiet();
    while (line_items.size() != 0 || rx_if.valid || due_reports.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    tmo_limit = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int send_pcts [7] = '{30, 0, 0, 50, 20, 70, 10};
    int recv_pcts [7] = '{30, 0, 20, 60, 0, 40, 0};
    logic [15:0] settings [7];
    rx_if.valid = 1'b0;
    rx_if.func = FuncByte;
    rx_if.rx_byte = '0;
    rx_if.new_phase = '0;
    res_if.ready = 1'b0;
    settings = '{TimeoutReset, 16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd0, 16'd12};
    settings[5] = 16'($urandom_range(2, 30));
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 20;
    push_item(FuncUnused, 8'hFF, 4'hF);
    push_phase(4'hF);
    push_phase(PhPowerupReq);
    push_byte(EscByte);
    push_byte(StartByte ^ EscXor);
    push_frame(PrimPowerupAck, 32'h0, 1'b1, FrameLen, 0);
    push_tick();
    push_phase(PhTransfer);
    push_frame(PrimDataReq, 32'hFFFF_FFFF, 1'b1, FrameLen, 0);
    wait_quiet();

    for (int s = 0; s < 7; s++) begin
      if (s != 0) write_timeout(settings[s]);
      send_idle_pct = send_pcts[s];
      recv_idle_pct = recv_pcts[s];
      gen_session(SessionItems);
      if (s == 2) begin
        @(posedge clk_i);
        long_req++;
      end
      wait_quiet();
    end

    if (due_reports.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_reports.size());
      n_errors++;
    end
    $display("Run covered %0d items with %0d complete frames and %0d timeouts,",
             n_items, n_frames, n_timeouts);
    $display("over seven byte timeout settings from 0 to 65535; %0d mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
